### rtl/assert_macros.svh
// Assertion helpers used by the bound property module in rtl/tlvsw_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tlvsw_pkg.sv
`default_nettype none

package tlvsw_pkg;

  localparam int unsigned HdrLenW = 16;

  // byte roles
  localparam logic [2:0] ROLE_HEADER  = 3'd0;
  localparam logic [2:0] ROLE_TYPE_HI = 3'd1;
  localparam logic [2:0] ROLE_TYPE_LO = 3'd2;
  localparam logic [2:0] ROLE_LEN_HI  = 3'd3;
  localparam logic [2:0] ROLE_LEN_LO  = 3'd4;
  localparam logic [2:0] ROLE_VALUE   = 3'd5;

  // message status
  localparam logic [1:0] STATUS_BUSY  = 2'd0;
  localparam logic [1:0] STATUS_CLEAN = 2'd1;
  localparam logic [1:0] STATUS_TRUNC = 2'd2;

  typedef enum logic [5:0] {
    PH_HEADER  = 6'b000001,
    PH_TYPE_HI = 6'b000010,
    PH_TYPE_LO = 6'b000100,
    PH_LEN_HI  = 6'b001000,
    PH_LEN_LO  = 6'b010000,
    PH_VALUE   = 6'b100000
  } tlvsw_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } tlvsw_beat_t;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [15:0] option_type;
    logic [15:0] value_length;
    logic [7:0]  value_byte;
    logic [15:0] value_offset;
    logic        record_end;
    logic [1:0]  message_status;
  } tlvsw_result_t;

endpackage

`default_nettype wire

### rtl/tlvsw_step.sv
`default_nettype none

module tlvsw_step
  import tlvsw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 fire,
  input  wire tlvsw_beat_t          beat,
  input  wire logic [HdrLenW-1:0]   header_length,
  output tlvsw_result_t             result
);

  tlvsw_phase_t phase, phase_next, run_phase;
  logic [15:0]  header_count, header_count_next;
  logic [15:0]  record_type, record_type_next;
  logic [15:0]  record_length, record_length_next;
  logic [15:0]  value_count, value_count_next;
  logic [15:0]  count_inc;

  // once the header is used up, this byte opens the first record
  assign run_phase = (phase == PH_HEADER && header_count >= header_length) ?
                     PH_TYPE_HI : phase;
  assign count_inc = value_count + 16'd1;

  always_comb begin
    phase_next         = run_phase;
    header_count_next  = header_count;
    record_type_next   = record_type;
    record_length_next = record_length;
    value_count_next   = value_count;
    result             = '0;

    case (run_phase)
      PH_HEADER: begin
        result.byte_role  = ROLE_HEADER;
        header_count_next = header_count + 16'd1;
      end
      PH_TYPE_HI: begin
        result.byte_role   = ROLE_TYPE_HI;
        record_type_next   = {beat.data_byte, 8'h00};
        record_length_next = '0;
        value_count_next   = '0;
        phase_next         = PH_TYPE_LO;
      end
      PH_TYPE_LO: begin
        result.byte_role   = ROLE_TYPE_LO;
        record_type_next   = {record_type[15:8], beat.data_byte};
        result.option_type = {record_type[15:8], beat.data_byte};
        phase_next         = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        result.byte_role   = ROLE_LEN_HI;
        record_length_next = {beat.data_byte, 8'h00};
        result.option_type = record_type;
        phase_next         = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        result.byte_role    = ROLE_LEN_LO;
        record_length_next  = {record_length[15:8], beat.data_byte};
        result.option_type  = record_type;
        result.value_length = {record_length[15:8], beat.data_byte};
        value_count_next    = '0;
        if ({record_length[15:8], beat.data_byte} == 16'd0) begin
          result.record_end = 1'b1;
          phase_next        = PH_TYPE_HI;
        end else begin
          phase_next = PH_VALUE;
        end
      end
      PH_VALUE: begin
        result.byte_role    = ROLE_VALUE;
        result.option_type  = record_type;
        result.value_length = record_length;
        result.value_byte   = beat.data_byte;
        result.value_offset = value_count;
        value_count_next    = count_inc;
        if (count_inc >= record_length) begin
          result.record_end = 1'b1;
          phase_next        = PH_TYPE_HI;
        end
      end
      default: begin
        phase_next = PH_TYPE_HI;
      end
    endcase

    if (beat.last_byte) begin
      result.message_status = (run_phase == PH_HEADER || result.record_end) ?
                              STATUS_CLEAN : STATUS_TRUNC;
      // drop the walk, next beat starts a new message
      phase_next         = PH_HEADER;
      header_count_next  = '0;
      record_type_next   = '0;
      record_length_next = '0;
      value_count_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      header_count  <= '0;
      record_type   <= '0;
      record_length <= '0;
      value_count   <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      record_type   <= record_type_next;
      record_length <= record_length_next;
      value_count   <= value_count_next;
    end
  end

endmodule

`default_nettype wire

### rtl/tlvsw_out_buf.sv
`default_nettype none

module tlvsw_out_buf
  import tlvsw_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tlvsw_result_t push_data,
  output logic               can_push,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tlvsw_result_t      out_data
);

  logic          main_valid;
  logic          skid_valid;
  tlvsw_result_t main_data;
  tlvsw_result_t skid_data;
  logic          pop;

  assign pop       = main_valid && out_ready;
  assign can_push  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push) begin
      // park the beat in the skid stage while the output is stalled
      if (main_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/tlv_stream_walker_core.sv
// TLV stream walker.
// Input channel (in_valid/in_ready/in_data) carries one message byte per beat
// with a flag on the final byte. The first header_length bytes of a message
// are tagged as header; after that the bytes are walked as records of a
// 16-bit big-endian type, a 16-bit big-endian length and that many value bytes.
// Every input beat yields exactly one output beat (out_valid/out_ready/out_data)
// with the byte role, type, length, value byte and offset, a record-end flag,
// and on the final byte a clean or truncated status.
// Throughput is one byte per clock while in_ready is high, set by the single
// walker state update per beat. in_ready comes from a register: a two-entry
// output buffer (output register plus skid stage) lets one more beat in while
// the receiver stalls, then in_ready drops until the stalled beat is taken.
// Reset (synchronous, active high) empties the output buffer, clears the walk
// state and sets header_length to 0. header_length is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle,
// which the block itself does not enforce.
`default_nettype none

module tlv_stream_walker_core
  import tlvsw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tlvsw_beat_t        in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tlvsw_result_t           out_data,
  input  wire logic               cfg_we,
  input  wire logic [HdrLenW-1:0] cfg_wdata
);

  logic [HdrLenW-1:0] header_length;
  logic               fire;
  tlvsw_result_t      step_result;

  assign fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_length <= '0;
    end else if (cfg_we) begin
      header_length <= cfg_wdata;
    end
  end

  tlvsw_step u_step (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .beat          (in_data),
    .header_length (header_length),
    .result        (step_result)
  );

  tlvsw_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (step_result),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### rtl/tlvsw_checker.sv
`default_nettype none
`include "assert_macros.svh"

module tlvsw_props
  import tlvsw_pkg::*;
(
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire tlvsw_result_t out_data
);

  logic end_seen;
  logic trunc_seen;
  logic value_seen;
  logic closing_role;
  logic open_role;
  logic offset_ok;

  assign end_seen     = out_valid && out_data.record_end;
  assign trunc_seen   = out_valid && out_data.message_status == STATUS_TRUNC;
  assign value_seen   = out_valid && out_data.byte_role == ROLE_VALUE;
  assign closing_role = out_data.byte_role == ROLE_LEN_LO || out_data.byte_role == ROLE_VALUE;
  assign open_role    = !out_data.record_end && out_data.byte_role != ROLE_HEADER;
  assign offset_ok    = out_data.value_offset < out_data.value_length;

  `ASSERT_IMP(a_reset_empty, $fell(rst), !out_valid && in_ready, "output not empty after reset")

  `ASSERT_IMP(a_stall_full, !in_ready, out_valid, "input stalled with empty output")

  `ASSERT_IMP(a_end_role, end_seen, closing_role, "record end on a non-closing byte")

  `ASSERT_IMP(a_trunc_open, trunc_seen, open_role, "truncation flagged at a record boundary")

  `ASSERT_IMP(a_offset_range, value_seen, offset_ok, "value offset past record length")

endmodule

bind tlv_stream_walker_core tlvsw_props u_tlvsw_props (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire

### verif/tlvsw_checker.sv
`default_nettype none

module tlvsw_checker
  import tlvsw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire tlvsw_beat_t        in_data,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire tlvsw_result_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [HdrLenW-1:0] cfg_wdata,
  output int                      errors,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the walker
  logic [HdrLenW-1:0] hdr_len = '0;
  logic [2:0]         cur_phase = ROLE_HEADER;
  logic [15:0]        hdr_seen = '0;
  logic [15:0]        rec_type = '0;
  logic [15:0]        rec_len = '0;
  logic [15:0]        val_idx = '0;

  tlvsw_result_t predicted_beats[$];
  tlvsw_result_t want;

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic void clear_walk();
    cur_phase = ROLE_HEADER;
    hdr_seen = '0;
    rec_type = '0;
    rec_len = '0;
    val_idx = '0;
  endfunction

  function automatic tlvsw_result_t walk_byte(input tlvsw_beat_t beat);
    tlvsw_result_t r;
    r = '0;
    // header phase ends once enough bytes have been skipped
    if (cur_phase == ROLE_HEADER && hdr_seen >= hdr_len) cur_phase = ROLE_TYPE_HI;
    r.byte_role = cur_phase;
    case (cur_phase)
      ROLE_HEADER: begin
        hdr_seen = hdr_seen + 16'd1;
      end
      ROLE_TYPE_HI: begin
        rec_type = {beat.data_byte, 8'h00};
        rec_len = '0;
        val_idx = '0;
        cur_phase = ROLE_TYPE_LO;
      end
      ROLE_TYPE_LO: begin
        rec_type = rec_type | {8'h00, beat.data_byte};
        r.option_type = rec_type;
        cur_phase = ROLE_LEN_HI;
      end
      ROLE_LEN_HI: begin
        rec_len = {beat.data_byte, 8'h00};
        r.option_type = rec_type;
        cur_phase = ROLE_LEN_LO;
      end
      ROLE_LEN_LO: begin
        rec_len = rec_len | {8'h00, beat.data_byte};
        r.option_type = rec_type;
        r.value_length = rec_len;
        val_idx = '0;
        if (rec_len == 16'd0) begin
          r.record_end = 1'b1;
          cur_phase = ROLE_TYPE_HI;
        end else begin
          cur_phase = ROLE_VALUE;
        end
      end
      default: begin
        r.option_type = rec_type;
        r.value_length = rec_len;
        r.value_byte = beat.data_byte;
        r.value_offset = val_idx;
        val_idx = val_idx + 16'd1;
        if (val_idx >= rec_len) begin
          r.record_end = 1'b1;
          cur_phase = ROLE_TYPE_HI;
        end
      end
    endcase
    r.message_status = STATUS_BUSY;
    if (beat.last_byte) begin
      r.message_status = (r.byte_role == ROLE_HEADER || r.record_end) ? STATUS_CLEAN
                                                                      : STATUS_TRUNC;
      clear_walk();
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t tlvsw_checker: %s expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hdr_len = '0;
      clear_walk();
      predicted_beats.delete();
    end else begin
      // retire the output beat before predicting a new one: the output is registered
      if (out_valid && out_ready) begin
        if (predicted_beats.size() == 0) begin
          errors++;
          $display("%0t tlvsw_checker: beat expected none actual %h", $time, out_data);
        end else begin
          want = predicted_beats.pop_front();
          check_field("byte_role", 16'(want.byte_role), 16'(out_data.byte_role));
          check_field("option_type", want.option_type, out_data.option_type);
          check_field("value_length", want.value_length, out_data.value_length);
          check_field("value_byte", 16'(want.value_byte), 16'(out_data.value_byte));
          check_field("value_offset", want.value_offset, out_data.value_offset);
          check_field("record_end", 16'(want.record_end), 16'(out_data.record_end));
          check_field("message_status", 16'(want.message_status),
                      16'(out_data.message_status));
        end
      end
      if (in_valid && in_ready) predicted_beats.push_back(walk_byte(in_data));
      if (cfg_we) hdr_len = cfg_wdata;
    end
    pending = predicted_beats.size();
  end

endmodule

`default_nettype wire

### verif/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlvsw_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  tlvsw_beat_t        in_data = '0;
  logic               out_ready = 1'b0;
  logic               cfg_we = 1'b0;
  logic [HdrLenW-1:0] cfg_wdata = '0;
  logic               in_ready;
  logic               out_valid;
  tlvsw_result_t      out_data;

  int fail_count;
  int pending_results;
  int beats_sent = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_span = 0;
  int stall_tick = 0;

  tlvsw_beat_t msg[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  tlv_stream_walker_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tlvsw_checker chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (fail_count),
    .pending   (pending_results)
  );

  // receiver: switch between open, random, starved and periodic stall patterns
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 200);
    end else begin
      stall_span--;
    end
    stall_tick++;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (stall_tick % 5 != 0);
    endcase
  end

  task automatic send_beat(input logic [7:0] d, input logic l);
    int gap;
    in_valid <= 1'b1;
    in_data <= '{data_byte: d, last_byte: l};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    // hold valid through a burst, then drop it for a random gap
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold off until every predicted beat has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_hdr(input logic [HdrLenW-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic put_byte(input logic [7:0] d);
    msg.push_back('{data_byte: d, last_byte: 1'b0});
  endtask

  task automatic make_message(input int unsigned hdr);
    int unsigned kind;
    int unsigned n_rec;
    int unsigned cut;
    int unsigned pick;
    logic [15:0] typ;
    logic [15:0] len;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // noise: random bytes with stray end flags
      repeat ($urandom_range(1, 12))
        msg.push_back('{data_byte: 8'($urandom), last_byte: ($urandom_range(0, 5) == 0)});
    end else begin
      repeat (hdr) put_byte(8'($urandom));
      n_rec = $urandom_range(0, 4);
      if (hdr == 0 && n_rec == 0) n_rec = 1;
      repeat (n_rec) begin
        pick = $urandom_range(0, 7);
        typ = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'h0000 : 16'($urandom);
        len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(20, 60))
                                          : 16'($urandom_range(0, 6));
        put_byte(typ[15:8]);
        put_byte(typ[7:0]);
        put_byte(len[15:8]);
        put_byte(len[7:0]);
        repeat (len) put_byte(8'($urandom));
      end
      // cut some messages short, anywhere in the header or the records
      if (kind <= 2) begin
        cut = $urandom_range(0, msg.size() - 1);
        while (msg.size() > cut + 1) void'(msg.pop_back());
      end
    end
    msg[msg.size() - 1].last_byte = 1'b1;
    foreach (msg[i]) send_beat(msg[i].data_byte, msg[i].last_byte);
    msg.delete();
  endtask

  initial begin
    int unsigned hdr;
    int unsigned sel;
    int unsigned phase_end;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_hdr(16'h0000);
    // zero-length record ending the message cleanly
    send_beat(8'hFF, 1'b0); send_beat(8'hFF, 1'b0); send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b1);
    // two value bytes, clean end on the last one
    send_beat(8'h00, 1'b0); send_beat(8'h00, 1'b0); send_beat(8'h00, 1'b0);
    send_beat(8'h02, 1'b0); send_beat(8'hFF, 1'b0); send_beat(8'h00, 1'b1);
    // end inside type high, type low, length high
    send_beat(8'h12, 1'b1);
    send_beat(8'hAB, 1'b0); send_beat(8'hCD, 1'b1);
    send_beat(8'h12, 1'b0); send_beat(8'h34, 1'b0); send_beat(8'h00, 1'b1);
    // maximum length, end on the first value byte
    send_beat(8'h56, 1'b0); send_beat(8'h78, 1'b0); send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b0); send_beat(8'h5A, 1'b1);
    drain();

    // message ending within its header
    write_hdr(16'd2);
    send_beat(8'h11, 1'b0); send_beat(8'h22, 1'b1);
    drain();
    write_hdr(16'hFFFF);
    send_beat(8'hC3, 1'b0); send_beat(8'h3C, 1'b0); send_beat(8'h99, 1'b1);
    drain();

    while (beats_sent < 1460) begin
      sel = $urandom_range(0, 5);
      case (sel)
        0, 4: hdr = 0;
        1: hdr = 1;
        2: hdr = 2;
        3: hdr = $urandom_range(3, 8);
        default: hdr = $urandom_range(9, 30);
      endcase
      write_hdr(16'(hdr));
      phase_end = beats_sent + $urandom_range(80, 250);
      while (beats_sent < phase_end) make_message(hdr);
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

`default_nettype wire
